// ===== hw/rtl/hsv_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV pipeline.
package hsv_pkg;

    localparam int CHAN_BITS = 8;
    localparam int QUO_BITS  = 15;
    localparam int NUM_BITS  = QUO_BITS + CHAN_BITS;
    localparam int CELLS     = QUO_BITS;

    localparam logic [23:0] HUE_SPAN_60 = 24'd3840;
    localparam logic [23:0] HUE_OFF_120 = 24'd7680;
    localparam logic [23:0] HUE_OFF_240 = 24'd15360;
    localparam logic [23:0] HUE_OFF_360 = 24'd23040;
    localparam logic [23:0] PCT_ONE     = 24'd25600;
    localparam logic [15:0] PCT_SCALE   = 16'd100;

    // One restoring divider lane: partial remainder, and a word that shifts
    // numerator bits out at the top while quotient bits enter at the bottom.
    typedef struct packed {
        logic [CHAN_BITS-1:0] rem;
        logic [QUO_BITS-1:0]  work;
        logic [CHAN_BITS-1:0] divisor;
    } hsv_div_t;

    typedef struct packed {
        hsv_div_t            hue;
        hsv_div_t            sat;
        logic [QUO_BITS-1:0] value;
    } hsv_stage_t;

    function automatic hsv_div_t div_step(input hsv_div_t cur);
        hsv_div_t           nxt;
        logic [CHAN_BITS:0] trial;
        logic [CHAN_BITS:0] diff;
        trial = {cur.rem, cur.work[QUO_BITS-1]};
        diff  = trial - {1'b0, cur.divisor};
        nxt.divisor = cur.divisor;
        if (trial >= {1'b0, cur.divisor})
        begin
            nxt.rem  = diff[CHAN_BITS-1:0];
            nxt.work = {cur.work[QUO_BITS-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = trial[CHAN_BITS-1:0];
            nxt.work = {cur.work[QUO_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/rgb_to_hsv_converter_top.sv =====
// Pipeline: an input transfer passes the front cell and then 15 divider cells to m_axis_tvalid.
// Throughput: one pixel per cycle while the chain advances; each divider cell resolves one
// quotient bit of hue and saturation, so the 15-bit quotient width sets the chain length.
// Backpressure holds the whole chain; s_axis_tready drops only while a result waits unread.
// Reset (rst_n, asynchronous) clears the valid flags of every cell; data registers are not reset.
module rgb_to_hsv_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // hue[14:0], saturation[29:15], value[44:30], zero[47:45]
);

    logic                advance;
    logic                cell_valid [hsv_pkg::CELLS+1];
    hsv_pkg::hsv_stage_t cell_data  [hsv_pkg::CELLS+1];

    // Advance the chain whenever the last cell is empty or its result is taken.
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    hsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (cell_valid[0]),
        .out_data  (cell_data[0])
    );

    for (genvar i = 0; i < hsv_pkg::CELLS; i++)
    begin : g_cell
        hsv_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    assign m_axis_tvalid = cell_valid[hsv_pkg::CELLS];
    assign m_axis_tdata  = {3'b000,
                            cell_data[hsv_pkg::CELLS].value,
                            cell_data[hsv_pkg::CELLS].sat.work,
                            cell_data[hsv_pkg::CELLS].hue.work};

endmodule

// ===== hw/rtl/hsv_front.sv =====
// Front cell: max/min search, hue and saturation numerators, value by reciprocal.
module hsv_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             in_valid,
    input  logic [hsv_pkg::CHAN_BITS-1:0]    red,
    input  logic [hsv_pkg::CHAN_BITS-1:0]    green,
    input  logic [hsv_pkg::CHAN_BITS-1:0]    blue,
    output logic                             out_valid,
    output hsv_pkg::hsv_stage_t              out_data
);

    logic                          valid_reg;
    hsv_pkg::hsv_stage_t           data_reg;
    hsv_pkg::hsv_stage_t           data_next;

    logic [hsv_pkg::CHAN_BITS-1:0] mx;
    logic [hsv_pkg::CHAN_BITS-1:0] mn;
    logic [hsv_pkg::CHAN_BITS-1:0] dlt;
    logic [hsv_pkg::CHAN_BITS-1:0] plus_ch;
    logic [hsv_pkg::CHAN_BITS-1:0] minus_ch;
    logic [23:0]                   offset;
    logic [23:0]                   hue_num;
    logic [23:0]                   sat_num;
    logic [15:0]                   val_base;
    logic [24:0]                   val_frac;
    logic [16:0]                   val_base_inc;

    always_comb
    begin
        // Red wins ties, then green.
        if (red >= green && red >= blue)
        begin
            mx       = red;
            plus_ch  = green;
            minus_ch = blue;
            offset   = (green >= blue) ? 24'd0 : hsv_pkg::HUE_OFF_360;
        end
        else if (green >= blue)
        begin
            mx       = green;
            plus_ch  = blue;
            minus_ch = red;
            offset   = hsv_pkg::HUE_OFF_120;
        end
        else
        begin
            mx       = blue;
            plus_ch  = red;
            minus_ch = green;
            offset   = hsv_pkg::HUE_OFF_240;
        end

        mn = red;
        if (green < mn)
            mn = green;
        if (blue < mn)
            mn = blue;
        dlt = mx - mn;

        // Numerator never goes negative; modular arithmetic lands on the true value.
        hue_num = offset * 24'(dlt) + hsv_pkg::HUE_SPAN_60 * 24'(plus_ch)
                - hsv_pkg::HUE_SPAN_60 * 24'(minus_ch);
        sat_num = hsv_pkg::PCT_ONE * 24'(dlt);

        // 25600*mx/255 = 100*mx + floor(100*mx/255); y/255 as (y+1)*257 >> 16.
        val_base     = 16'(mx) * hsv_pkg::PCT_SCALE;
        val_base_inc = 17'(val_base) + 17'd1;
        val_frac     = (25'(val_base_inc) << 8) + 25'(val_base_inc);

        data_next.value = 15'(val_base) + 15'(val_frac[24:16]);

        // Gray pixel: divide zero by one so the hue comes out zero.
        if (dlt == '0)
        begin
            data_next.hue.rem     = '0;
            data_next.hue.work    = '0;
            data_next.hue.divisor = 8'd1;
        end
        else
        begin
            data_next.hue.rem     = hue_num[hsv_pkg::NUM_BITS-1:hsv_pkg::QUO_BITS];
            data_next.hue.work    = hue_num[hsv_pkg::QUO_BITS-1:0];
            data_next.hue.divisor = dlt;
        end

        // Black pixel: saturation zero.
        if (mx == '0)
        begin
            data_next.sat.rem     = '0;
            data_next.sat.work    = '0;
            data_next.sat.divisor = 8'd1;
        end
        else
        begin
            data_next.sat.rem     = sat_num[hsv_pkg::NUM_BITS-1:hsv_pkg::QUO_BITS];
            data_next.sat.work    = sat_num[hsv_pkg::QUO_BITS-1:0];
            data_next.sat.divisor = mx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/hsv_div_cell.sv =====
// Divider cell: one quotient bit for both the hue and saturation lanes.
module hsv_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  hsv_pkg::hsv_stage_t in_data,
    output logic                out_valid,
    output hsv_pkg::hsv_stage_t out_data
);

    logic                valid_reg;
    hsv_pkg::hsv_stage_t data_reg;
    hsv_pkg::hsv_stage_t data_next;

    always_comb
    begin
        data_next.hue   = hsv_pkg::div_step(in_data.hue);
        data_next.sat   = hsv_pkg::div_step(in_data.sat);
        data_next.value = in_data.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/hsv_checker.sv =====
// Port-level checks for the RGB to HSV converter, bound to the top level.
module hsv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // A stalled result holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An empty output stage never blocks the input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_hue: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:0] < 15'd23040)
        else $error("hue out of range");

    a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[29:15] <= 15'd25600 && m_axis_tdata[44:30] <= 15'd25600)
        else $error("saturation or value out of range");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:45] == 3'b000)
        else $error("nonzero pad bits");

endmodule

bind rgb_to_hsv_converter_top hsv_checker u_hsv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_rgb_to_hsv_converter_top.sv =====
// Self-checking testbench for the RGB to HSV stream converter.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_top;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_DEPTH   = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_LIMIT = 60;

    // Fixed-point scale factors: hue in 1/64 degree, percent in 1/256.
    localparam int DEG_60   = 3840;
    localparam int DEG_120  = 7680;
    localparam int DEG_240  = 15360;
    localparam int DEG_360  = 23040;
    localparam int FULL_PCT = 25600;
    localparam int CHAN_MAX = 255;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] hue;
        logic [14:0] sat;
        logic [14:0] val;
    } hsv_expect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // hue[14:0], saturation[29:15], value[44:30]

    hsv_expect_t pixel_expected[$];

    int s_idle_pct = 0;
    int r_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int mismatch_count = 0;
    int pixels_in = 0;
    int results_checked = 0;
    int gray_pixels = 0;
    int black_pixels = 0;
    int max_by_chan[3] = '{0, 0, 0};

    rgb_to_hsv_converter_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    function automatic hsv_expect_t hsv_of_pixel(input logic [7:0] r, g, b);
        hsv_expect_t res;
        int ri;
        int gi;
        int bi;
        int mx;
        int mn;
        int d;
        int num;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        d = mx - mn;
        // Ties on the maximum go to red first, then green.
        if (d == 0)
            num = 0;
        else if (mx == ri)
            num = (gi >= bi) ? DEG_60 * (gi - bi) : DEG_360 * d - DEG_60 * (bi - gi);
        else if (mx == gi)
            num = DEG_120 * d + DEG_60 * (bi - ri);
        else
            num = DEG_240 * d + DEG_60 * (ri - gi);
        res.red   = r;
        res.green = g;
        res.blue  = b;
        res.hue   = (d == 0) ? 15'd0 : 15'(num / d);
        res.sat   = (mx == 0) ? 15'd0 : 15'((FULL_PCT * d) / mx);
        res.val   = 15'((FULL_PCT * mx) / CHAN_MAX);
        return res;
    endfunction

    task automatic note_mismatch(input string field, input hsv_expect_t e,
                                 input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch for rgb(%0d,%0d,%0d): expected %0d, actual %0d",
                     $time, field, e.red, e.green, e.blue, want, got);
    endtask

    // Record accepted pixels, then check the result transfer of the same edge.
    always @(posedge clk)
    begin : score_pixels
        hsv_expect_t e;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            r = s_axis_tdata[7:0];
            g = s_axis_tdata[15:8];
            b = s_axis_tdata[23:16];
            e = hsv_of_pixel(r, g, b);
            pixel_expected.push_back(e);
            pixels_in++;
            if (r == g && g == b)
                gray_pixels++;
            if (r == 0 && g == 0 && b == 0)
                black_pixels++;
            if (r >= g && r >= b)
                max_by_chan[0]++;
            else if (g >= b)
                max_by_chan[1]++;
            else
                max_by_chan[2]++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_expected.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                e = pixel_expected.pop_front();
                results_checked++;
                if (m_axis_tdata[14:0] !== e.hue)
                    note_mismatch("hue", e, e.hue, m_axis_tdata[14:0]);
                if (m_axis_tdata[29:15] !== e.sat)
                    note_mismatch("saturation", e, e.sat, m_axis_tdata[29:15]);
                if (m_axis_tdata[44:30] !== e.val)
                    note_mismatch("value", e, e.val, m_axis_tdata[44:30]);
            end
        end
    end

    // Receiver: random backpressure, or a long hold on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic set_idle(input int sender_pct, input int receiver_pct);
        s_idle_pct = sender_pct;
        r_idle_pct <= receiver_pct;
    endtask

    task automatic send_pixel(input logic [7:0] r, g, b);
        while ($urandom_range(99) < s_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid and hold until every outstanding result has been checked.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixel_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corners();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd1,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd1);
        send_pixel(8'd1,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd254, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd10,  8'd200, 8'd100);
        send_pixel(8'd170, 8'd85,  8'd255);
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
    endtask

    // Channels close together: small max-min, frequent ties and gray pixels.
    task automatic test_near_gray(input int count);
        int base;
        int ch[3];
        repeat (count)
        begin
            base = $urandom_range(255);
            foreach (ch[i])
            begin
                ch[i] = base + $urandom_range(6) - 3;
                if (ch[i] < 0) ch[i] = 0;
                if (ch[i] > 255) ch[i] = 255;
            end
            send_pixel(8'(ch[0]), 8'(ch[1]), 8'(ch[2]));
        end
    endtask

    // Hold the receiver off while the sender keeps offering, so the chain fills.
    task automatic test_full_stall(input int count);
        int saved_pct;
        saved_pct = s_idle_pct;
        s_idle_pct = 0;
        hold_req <= hold_req + 1;
        test_random_pixels(count);
        s_idle_pct = saved_pct;
        pause_until_drained();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(38, 79);
        test_corners();
        test_random_pixels(150);
        test_near_gray(50);
        test_full_stall(60);

        set_idle(79, 38);
        test_random_pixels(150);
        test_near_gray(50);

        set_idle(0, 0);
        test_random_pixels(150);
        test_near_gray(50);

        pause_until_drained();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Covered %0d pixels (%0d gray, %0d black; max in r/g/b: %0d/%0d/%0d),",
                 pixels_in, gray_pixels, black_pixels,
                 max_by_chan[0], max_by_chan[1], max_by_chan[2]);
        $display("%0d results checked under random and long backpressure, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pixel_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
